### rtl/core/tdoa_hyperbola_intersect_unit_defines.svh
// Assertion macros shared by the checkers of the hyperbola intersection unit.
`ifndef TDOA_HYPERBOLA_INTERSECT_UNIT_DEFINES_SVH
`define TDOA_HYPERBOLA_INTERSECT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define THI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hyperbola unit check failed");

// Next-cycle implication, disabled while reset is high.
`define THI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hyperbola unit check failed");

`endif

### rtl/core/thi_pkg.sv
// Types, constants and helper functions of the hyperbola intersection unit.
package thi_pkg;

   localparam int COORD_W    = 24;
   localparam int FRAC       = 20;
   localparam int HSQ_SHIFT  = 22;
   localparam int WORD_W     = 32;
   localparam int WIDE_W     = 34;
   localparam int EXT_W      = 36;
   localparam int HALF_W     = 22;
   localparam int ACC_W      = 21;
   localparam int DEPTH_W    = 6;
   localparam int LEVEL_W    = DEPTH_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 22;

   typedef logic signed [WORD_W-1:0]  word_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;
   typedef logic signed [EXT_W-1:0]   ext_type;
   typedef logic signed [COORD_W-1:0] coord_type;

   localparam word_type WMAX    = 32'sh7FFF_FFFF;
   localparam ext_type  ONE_EXT = ext_type'(64'sd1 << FRAC);

   localparam logic [1:0] CORNER_A = 2'd0;
   localparam logic [1:0] CORNER_B = 2'd1;
   localparam logic [1:0] CORNER_C = 2'd2;
   localparam logic [1:0] CORNER_D = 2'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_SPACING = 2'd0,
      CSR_ACCURACY     = 2'd1,
      CSR_MAX_DEPTH    = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_HSQ,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   typedef struct packed {
      logic       go;
      alu_op_type op;
      wide_type   a;
      wide_type   b;
   } alu_req_type;

   typedef struct packed {
      logic     done;
      word_type result;
   } alu_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PRE,
      S_SPAN,
      S_SPAN_DONE,
      S_LEVEL,
      S_PT_H,
      S_PT_HDONE,
      S_PT_VDONE,
      S_DECIDE,
      S_BR_SQU,
      S_BR_DIV,
      S_BR_MULP,
      S_BR_SQRT
   } state_type;

   function automatic word_type sat_word(input ext_type v);
      word_type r;
      if (v > ext_type'(WMAX)) begin
         r = WMAX;
      end else if (v < -ext_type'(WMAX)) begin
         r = -WMAX;
      end else begin
         r = word_type'(v);
      end
      return r;
   endfunction

   function automatic coord_type sat_coord(input ext_type v);
      ext_type   cmax;
      coord_type r;
      cmax = ext_type'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
      if (v > cmax) begin
         r = coord_type'(cmax);
      end else if (v < -cmax - ext_type'(1)) begin
         r = coord_type'(-cmax - ext_type'(1));
      end else begin
         r = coord_type'(v);
      end
      return r;
   endfunction

endpackage

### rtl/core/thi_alu.sv
// Shared arithmetic unit: fixed-point multiply, iterative divide and square root.
module thi_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  thi_pkg::alu_req_type req,
   output thi_pkg::alu_rsp_type rsp
);
   import thi_pkg::*;

   localparam int DQ_W   = WORD_W + FRAC;
   localparam int ROOT_W = DQ_W / 2;
   localparam int REM_W  = WORD_W + 1;
   localparam int CNT_W  = $clog2(DQ_W + 1);
   localparam int PROD_W = 64;

   logic                  busy_ff, busy_in;
   alu_op_type            op_ff, op_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DQ_W-1:0]       dq_ff, dq_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [WORD_W-1:0]     dvs_ff, dvs_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic                  neg_ff, neg_in;
   logic                  done_ff, done_in;
   word_type              res_ff, res_in;

   logic signed [2*WIDE_W-1:0] prod;
   logic signed [PROD_W-1:0]   prod64;
   logic signed [PROD_W-1:0]   shifted;
   word_type                   mul_res;
   word_type                   a_w;
   word_type                   b_w;
   logic [WORD_W-1:0]          mag_a;
   logic [WORD_W-1:0]          mag_b;
   logic [REM_W-1:0]           div_trial;
   logic                       div_ge;
   logic [ROOT_W+3:0]          sq_trial;
   logic [ROOT_W+3:0]          sq_sub;
   logic                       sq_ge;
   word_type                   div_mag;

   // Multiply wraps at 64 bits before the shift, as the integer arithmetic does.
   always_comb begin
      prod    = req.a * req.b;
      prod64  = prod[PROD_W-1:0];
      shifted = (req.op == ALU_HSQ) ? (prod64 >>> HSQ_SHIFT) : (prod64 >>> FRAC);
      if (shifted > PROD_W'(WMAX)) begin
         mul_res = WMAX;
      end else if (shifted < -PROD_W'(WMAX)) begin
         mul_res = -WMAX;
      end else begin
         mul_res = word_type'(shifted);
      end
   end

   assign a_w   = word_type'(req.a);
   assign b_w   = word_type'(req.b);
   assign mag_a = a_w[WORD_W-1] ? WORD_W'(-a_w) : WORD_W'(a_w);
   assign mag_b = b_w[WORD_W-1] ? WORD_W'(-b_w) : WORD_W'(b_w);

   assign div_trial = {rem_ff[WORD_W-1:0], dq_ff[DQ_W-1]};
   assign div_ge    = div_trial >= {1'b0, dvs_ff};
   assign sq_trial  = {rem_ff[ROOT_W+1:0], dq_ff[DQ_W-1:DQ_W-2]};
   assign sq_sub    = {2'b00, root_ff, 2'b01};
   assign sq_ge     = sq_trial >= sq_sub;
   assign div_mag   = (|dq_ff[DQ_W-1:WORD_W-1]) ? WMAX : word_type'({1'b0, dq_ff[WORD_W-2:0]});

   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      root_in = root_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (op_ff == ALU_DIV) begin
               res_in = neg_ff ? -div_mag : div_mag;
            end else begin
               res_in = word_type'(root_ff);
            end
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
            if (op_ff == ALU_DIV) begin
               rem_in = div_ge ? (div_trial - {1'b0, dvs_ff}) : div_trial;
               dq_in  = {dq_ff[DQ_W-2:0], div_ge};
            end else begin
               rem_in  = sq_ge ? REM_W'(sq_trial - sq_sub) : REM_W'(sq_trial);
               root_in = {root_ff[ROOT_W-2:0], sq_ge};
               dq_in   = {dq_ff[DQ_W-3:0], 2'b00};
            end
         end
      end else if (req.go) begin
         op_in = req.op;
         unique case (req.op)
            ALU_MUL, ALU_HSQ: begin
               done_in = 1'b1;
               res_in  = mul_res;
            end
            ALU_DIV: begin
               if (b_w == '0) begin
                  done_in = 1'b1;
                  if (a_w == '0) begin
                     res_in = '0;
                  end else begin
                     res_in = a_w[WORD_W-1] ? -WMAX : WMAX;
                  end
               end else begin
                  busy_in = 1'b1;
                  cnt_in  = CNT_W'(DQ_W);
                  dq_in   = {mag_a, {FRAC{1'b0}}};
                  rem_in  = '0;
                  dvs_in  = mag_b;
                  neg_in  = a_w[WORD_W-1] ^ b_w[WORD_W-1];
               end
            end
            ALU_SQRT: begin
               if (a_w <= 0) begin
                  done_in = 1'b1;
                  res_in  = '0;
               end else begin
                  busy_in = 1'b1;
                  cnt_in  = CNT_W'(ROOT_W);
                  dq_in   = {a_w[WORD_W-1:0], {FRAC{1'b0}}};
                  rem_in  = '0;
                  root_in = '0;
               end
            end
            default: begin
               done_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      dq_ff   <= dq_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      root_ff <= root_in;
      neg_ff  <= neg_in;
      res_ff  <= res_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

endmodule

### rtl/core/tdoa_hyperbola_intersect_unit.sv
// Top level of the four-sensor hyperbola intersection unit.
// One start beat carries four distance differences and yields four result beats, in the
// corner order a, d, b, c, the fourth marked by rsp_last; each result sits on the rsp_ ports
// for one cycle under rsp_valid and cannot be held off. busy is high from the accepted start
// until the last result is issued. Every multiply, divide and root goes through one shared
// unit: a divide yields one quotient bit per cycle and a root one root bit per cycle.
// Each corner searches at most max_depth + 1 levels (the reset depth is 20), fewer once
// accuracy is met.
module tdoa_hyperbola_intersect_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  thi_pkg::coord_type                req_diff_ab,
   input  thi_pkg::coord_type                req_diff_bc,
   input  thi_pkg::coord_type                req_diff_cd,
   input  thi_pkg::coord_type                req_diff_ad,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_corner_id,
   output thi_pkg::coord_type                rsp_x_pos,
   output thi_pkg::coord_type                rsp_y_pos,
   output logic                              rsp_last,
   input  logic                              csr_wr_en,
   input  logic [thi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [thi_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import thi_pkg::*;

   logic [HALF_W-1:0]  half_spacing_ff;
   logic [ACC_W-1:0]   accuracy_ff;
   logic [DEPTH_W-1:0] max_depth_ff;

   state_type           state_ff, state_in;
   state_type           ret_ff, ret_in;
   logic                wait_ff, wait_in;
   logic [2:0]          pre_idx_ff, pre_idx_in;
   logic [1:0]          k_ff, k_in;
   logic                pt_ff, pt_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   word_type            dab_ff, dab_in, dbc_ff, dbc_in, dcd_ff, dcd_in, dad_ff, dad_in;
   word_type            dd_ff, dd_in;
   word_type            h_ab_ff, h_ab_in, h_bc_ff, h_bc_in;
   word_type            h_cd_ff, h_cd_in, h_ad_ff, h_ad_in;
   word_type            br_s1_ff, br_s1_in, br_s2_ff, br_s2_in, br_val_ff, br_val_in;
   wide_type            br_u_ff, br_u_in;
   wide_type            lo_ff, lo_in, hi_ff, hi_in, quarter_ff, quarter_in;
   wide_type            xs0_ff, xs0_in, xs1_ff, xs1_in;
   word_type            yh0_ff, yh0_in, yh1_ff, yh1_in, yv0_ff, yv0_in, yv1_ff, yv1_in;
   logic [WORD_W:0]     gap0_ff, gap0_in, gap1_ff, gap1_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_corner_ff, rsp_corner_in;
   coord_type           rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                rsp_last_ff, rsp_last_in;

   alu_req_type         alu_req;
   alu_rsp_type         alu_rsp;

   word_type            d_w, d2_w;
   word_type            ab2, bc1, cd2, ad1;
   logic                sel_ab, sel_top;
   word_type            h1, h2, v1, v2, dv, vv;
   logic [1:0]          corner;
   wide_type            xs_cur;
   word_type            yh_cur;
   ext_type             half_ext;
   ext_type             span_diff, quarter_ext;
   word_type            yh_new, yv_new;
   ext_type             g_ext, neg_g;
   logic [WORD_W:0]     gap_new;
   logic                w1;
   wide_type            x_sel;
   word_type            yh_sel, yv_sel;
   logic [WORD_W:0]     gap_sel;
   logic                stop;

   thi_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         half_spacing_ff <= HALF_W'(524288);
         accuracy_ff     <= ACC_W'(105);
         max_depth_ff    <= DEPTH_W'(20);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_HALF_SPACING: half_spacing_ff <= csr_wdata[HALF_W-1:0];
            CSR_ACCURACY:     accuracy_ff     <= csr_wdata[ACC_W-1:0];
            CSR_MAX_DEPTH:    max_depth_ff    <= csr_wdata[DEPTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign d_w  = word_type'(half_spacing_ff);
   assign d2_w = d_w <<< 1;
   assign ab2  = sat_word(ext_type'(h_ab_ff) - ext_type'(dd_ff));
   assign bc1  = sat_word(ext_type'(h_bc_ff) - ext_type'(dd_ff));
   assign cd2  = sat_word(ext_type'(h_cd_ff) - ext_type'(dd_ff));
   assign ad1  = sat_word(ext_type'(h_ad_ff) - ext_type'(dd_ff));

   // Pairings run a, d, b, c; a and b use the ab hyperbola, a and d the ad vertical one.
   assign sel_ab  = (k_ff == 2'd0) || (k_ff == 2'd2);
   assign sel_top = !k_ff[1];
   assign h1 = sel_ab ? h_ab_ff : h_cd_ff;
   assign h2 = sel_ab ? ab2 : cd2;
   assign v1 = sel_top ? ad1 : bc1;
   assign v2 = sel_top ? h_ad_ff : h_bc_ff;
   assign dv = sel_ab ? dab_ff : dcd_ff;
   assign vv = sel_top ? dad_ff : dbc_ff;

   always_comb begin
      unique case (k_ff)
         2'd0:    corner = CORNER_A;
         2'd1:    corner = CORNER_D;
         2'd2:    corner = CORNER_B;
         default: corner = CORNER_C;
      endcase
   end

   assign xs_cur      = pt_ff ? xs1_ff : xs0_ff;
   assign yh_cur      = pt_ff ? yh1_ff : yh0_ff;
   assign half_ext    = (ext_type'(d2_w) + ext_type'(vv)) >>> 1;
   assign span_diff   = ext_type'(hi_ff) - ext_type'(lo_ff);
   assign quarter_ext = span_diff >>> 2;

   always_comb begin
      if (sel_ab) begin
         yh_new = (dv < 0) ? sat_word(ext_type'(d_w) + ext_type'(br_val_ff))
                           : sat_word(ext_type'(d_w) - ext_type'(br_val_ff));
      end else begin
         yh_new = (dv < 0) ? sat_word(ext_type'(d_w) - ext_type'(br_val_ff))
                           : sat_word(ext_type'(d_w) + ext_type'(br_val_ff));
      end
   end

   assign yv_new  = sel_top ? sat_word(ext_type'(d2_w) - ext_type'(br_val_ff)) : br_val_ff;
   assign g_ext   = ext_type'(yv_new) - ext_type'(yh_cur);
   assign neg_g   = -g_ext;
   assign gap_new = g_ext[EXT_W-1] ? neg_g[WORD_W:0] : g_ext[WORD_W:0];

   assign w1      = !(gap0_ff < gap1_ff);
   assign x_sel   = w1 ? xs1_ff : xs0_ff;
   assign yh_sel  = w1 ? yh1_ff : yh0_ff;
   assign yv_sel  = w1 ? yv1_ff : yv0_ff;
   assign gap_sel = w1 ? gap1_ff : gap0_ff;
   assign stop    = (gap_sel < (WORD_W+1)'(accuracy_ff)) ||
                    (level_ff > {1'b0, max_depth_ff});

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      wait_in       = wait_ff;
      pre_idx_in    = pre_idx_ff;
      k_in          = k_ff;
      pt_in         = pt_ff;
      level_in      = level_ff;
      dab_in        = dab_ff;
      dbc_in        = dbc_ff;
      dcd_in        = dcd_ff;
      dad_in        = dad_ff;
      dd_in         = dd_ff;
      h_ab_in       = h_ab_ff;
      h_bc_in       = h_bc_ff;
      h_cd_in       = h_cd_ff;
      h_ad_in       = h_ad_ff;
      br_s1_in      = br_s1_ff;
      br_s2_in      = br_s2_ff;
      br_u_in       = br_u_ff;
      br_val_in     = br_val_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      quarter_in    = quarter_ff;
      xs0_in        = xs0_ff;
      xs1_in        = xs1_ff;
      yh0_in        = yh0_ff;
      yh1_in        = yh1_ff;
      yv0_in        = yv0_ff;
      yv1_in        = yv1_ff;
      gap0_in       = gap0_ff;
      gap1_in       = gap1_ff;
      rsp_valid_in  = 1'b0;
      rsp_corner_in = rsp_corner_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_last_in   = rsp_last_ff;
      alu_req.go    = 1'b0;
      alu_req.op    = ALU_MUL;
      alu_req.a     = '0;
      alu_req.b     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               dab_in     = word_type'(req_diff_ab);
               dbc_in     = word_type'(req_diff_bc);
               dcd_in     = word_type'(req_diff_cd);
               dad_in     = word_type'(req_diff_ad);
               pre_idx_in = '0;
               wait_in    = 1'b0;
               state_in   = S_PRE;
            end
         end
         S_PRE: begin
            alu_req.go = !wait_ff;
            wait_in    = 1'b1;
            unique case (pre_idx_ff)
               3'd0: begin
                  alu_req.op = ALU_MUL;
                  alu_req.a  = wide_type'(d_w);
               end
               3'd1: begin
                  alu_req.op = ALU_HSQ;
                  alu_req.a  = wide_type'(dab_ff);
               end
               3'd2: begin
                  alu_req.op = ALU_HSQ;
                  alu_req.a  = wide_type'(dbc_ff);
               end
               3'd3: begin
                  alu_req.op = ALU_HSQ;
                  alu_req.a  = wide_type'(dcd_ff);
               end
               default: begin
                  alu_req.op = ALU_HSQ;
                  alu_req.a  = wide_type'(dad_ff);
               end
            endcase
            alu_req.b = alu_req.a;
            if (alu_rsp.done) begin
               wait_in = 1'b0;
               unique case (pre_idx_ff)
                  3'd0:    dd_in   = alu_rsp.result;
                  3'd1:    h_ab_in = alu_rsp.result;
                  3'd2:    h_bc_in = alu_rsp.result;
                  3'd3:    h_cd_in = alu_rsp.result;
                  default: h_ad_in = alu_rsp.result;
               endcase
               if (pre_idx_ff == 3'd4) begin
                  k_in     = '0;
                  state_in = S_SPAN;
               end else begin
                  pre_idx_in = pre_idx_ff + 3'd1;
               end
            end
         end
         S_SPAN: begin
            // The span root is a branch with the two hyperbola terms swapped, taken at 2d.
            br_s1_in = v2;
            br_s2_in = v1;
            br_u_in  = wide_type'(d2_w);
            ret_in   = S_SPAN_DONE;
            state_in = S_BR_SQU;
         end
         S_SPAN_DONE: begin
            if (vv < 0) begin
               lo_in = wide_type'(sat_word(ext_type'(d_w) - ext_type'(br_val_ff)));
               hi_in = wide_type'(sat_word(half_ext));
            end else begin
               lo_in = wide_type'(sat_word(ext_type'(d2_w) - half_ext));
               hi_in = wide_type'(sat_word(ext_type'(d_w) + ext_type'(br_val_ff)));
            end
            level_in = '0;
            state_in = S_LEVEL;
         end
         S_LEVEL: begin
            quarter_in = wide_type'(quarter_ext);
            xs0_in     = wide_type'(ext_type'(lo_ff) + quarter_ext);
            xs1_in     = wide_type'(ext_type'(hi_ff) - quarter_ext);
            level_in   = level_ff + LEVEL_W'(1);
            pt_in      = 1'b0;
            state_in   = S_PT_H;
         end
         S_PT_H: begin
            br_s1_in = h1;
            br_s2_in = h2;
            br_u_in  = sel_ab ? xs_cur
                              : wide_type'(sat_word(ext_type'(xs_cur) - ext_type'(d2_w)));
            ret_in   = S_PT_HDONE;
            state_in = S_BR_SQU;
         end
         S_PT_HDONE: begin
            if (pt_ff) begin
               yh1_in = yh_new;
            end else begin
               yh0_in = yh_new;
            end
            br_s1_in = v1;
            br_s2_in = v2;
            br_u_in  = wide_type'(sat_word(ext_type'(xs_cur) - ext_type'(d_w)));
            ret_in   = S_PT_VDONE;
            state_in = S_BR_SQU;
         end
         S_PT_VDONE: begin
            if (pt_ff) begin
               yv1_in   = yv_new;
               gap1_in  = gap_new;
               state_in = S_DECIDE;
            end else begin
               yv0_in   = yv_new;
               gap0_in  = gap_new;
               pt_in    = 1'b1;
               state_in = S_PT_H;
            end
         end
         S_DECIDE: begin
            if (stop) begin
               rsp_valid_in  = 1'b1;
               rsp_corner_in = corner;
               rsp_x_in      = sat_coord(ext_type'(x_sel));
               rsp_y_in      = sat_coord((ext_type'(yh_sel) + ext_type'(yv_sel)) >>> 1);
               rsp_last_in   = (k_ff == 2'd3);
               if (k_ff == 2'd3) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = S_SPAN;
               end
            end else begin
               // Keep the half of the range around the better quarter point.
               if (w1) begin
                  lo_in = wide_type'(ext_type'(lo_ff) + (ext_type'(quarter_ff) <<< 1));
               end else begin
                  hi_in = wide_type'(ext_type'(hi_ff) - (ext_type'(quarter_ff) <<< 1));
               end
               state_in = S_LEVEL;
            end
         end
         S_BR_SQU: begin
            alu_req.go = !wait_ff;
            alu_req.op = ALU_MUL;
            alu_req.a  = br_u_ff;
            alu_req.b  = br_u_ff;
            wait_in    = 1'b1;
            if (alu_rsp.done) begin
               wait_in   = 1'b0;
               br_val_in = alu_rsp.result;
               state_in  = S_BR_DIV;
            end
         end
         S_BR_DIV: begin
            alu_req.go = !wait_ff;
            alu_req.op = ALU_DIV;
            alu_req.a  = wide_type'(br_val_ff);
            alu_req.b  = wide_type'(br_s2_ff);
            wait_in    = 1'b1;
            if (alu_rsp.done) begin
               wait_in   = 1'b0;
               br_val_in = alu_rsp.result;
               state_in  = S_BR_MULP;
            end
         end
         S_BR_MULP: begin
            alu_req.go = !wait_ff;
            alu_req.op = ALU_MUL;
            alu_req.a  = wide_type'(br_s1_ff);
            alu_req.b  = wide_type'(sat_word(ONE_EXT - ext_type'(br_val_ff)));
            wait_in    = 1'b1;
            if (alu_rsp.done) begin
               wait_in   = 1'b0;
               br_val_in = alu_rsp.result;
               state_in  = S_BR_SQRT;
            end
         end
         S_BR_SQRT: begin
            alu_req.go = !wait_ff;
            alu_req.op = ALU_SQRT;
            alu_req.a  = wide_type'(br_val_ff);
            wait_in    = 1'b1;
            if (alu_rsp.done) begin
               wait_in   = 1'b0;
               br_val_in = alu_rsp.result;
               state_in  = ret_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pre_idx_ff    <= pre_idx_in;
      k_ff          <= k_in;
      pt_ff         <= pt_in;
      level_ff      <= level_in;
      dab_ff        <= dab_in;
      dbc_ff        <= dbc_in;
      dcd_ff        <= dcd_in;
      dad_ff        <= dad_in;
      dd_ff         <= dd_in;
      h_ab_ff       <= h_ab_in;
      h_bc_ff       <= h_bc_in;
      h_cd_ff       <= h_cd_in;
      h_ad_ff       <= h_ad_in;
      br_s1_ff      <= br_s1_in;
      br_s2_ff      <= br_s2_in;
      br_u_ff       <= br_u_in;
      br_val_ff     <= br_val_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      quarter_ff    <= quarter_in;
      xs0_ff        <= xs0_in;
      xs1_ff        <= xs1_in;
      yh0_ff        <= yh0_in;
      yh1_ff        <= yh1_in;
      yv0_ff        <= yv0_in;
      yv1_ff        <= yv1_in;
      gap0_ff       <= gap0_in;
      gap1_ff       <= gap1_in;
      rsp_corner_ff <= rsp_corner_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_corner_id = rsp_corner_ff;
   assign rsp_x_pos     = rsp_x_ff;
   assign rsp_y_pos     = rsp_y_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

### rtl/core/thi_checker.sv
// Port-level checker of the hyperbola intersection unit and its bind.
`include "tdoa_hyperbola_intersect_unit_defines.svh"

module thi_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic       rsp_last,
   input logic [1:0] rsp_corner_id
);
   import thi_pkg::*;

   // An accepted start keeps the unit busy in the following cycle.
   `THI_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   // The final beat of an item is issued as the unit goes idle; earlier ones while busy.
   `THI_ASSERT_IMPL(a_last_idle, clock, reset, rsp_valid && rsp_last, !busy)
   `THI_ASSERT_IMPL(a_mid_busy, clock, reset, rsp_valid && !rsp_last, busy)
   // The c corner is always solved last.
   `THI_ASSERT_IMPL(a_last_corner, clock, reset, rsp_valid,
                    rsp_last == (rsp_corner_id == CORNER_C))

endmodule

bind tdoa_hyperbola_intersect_unit thi_checker u_thi_checker (.*);

### verif/tb_top.sv
// Self-checking testbench for the four-sensor hyperbola intersection unit.
module tb_top;
   import thi_pkg::*;

   localparam longint WM       = 64'sd2147483647;
   localparam longint ONE      = 64'sd1 << FRAC;
   localparam int     WATCHDOG = 250000;

   typedef struct {
      logic [1:0] corner;
      coord_type  x;
      coord_type  y;
      logic       last;
   } point_type;

   // Holds the register copy, predicts the four points of each shot and checks them.
   class hyperbola_board;
      longint unsigned half_spacing = 524288;
      longint unsigned accuracy     = 105;
      longint unsigned max_depth    = 20;
      point_type       expected_points[$];
      int              errors       = 0;

      function longint sat(longint v);
         if (v > WM) return WM;
         if (v < -WM) return -WM;
         return v;
      endfunction

      function longint fmul(longint a, longint b);
         return sat((a * b) >>> FRAC);
      endfunction

      function longint fdiv(longint a, longint b);
         if (b == 0) begin
            if (a == 0) return 0;
            return (a > 0) ? WM : -WM;
         end
         return sat((a * ONE) / b);
      endfunction

      function longint fsqrt(longint a);
         longint unsigned n, res, bits;
         if (a <= 0) return 0;
         res  = 0;
         bits = 64'd1 << 62;
         n    = longint'(a) << FRAC;
         while (bits > n) bits = bits >> 2;
         while (bits != 0) begin
            if (n >= res + bits) begin
               n   = n - (res + bits);
               res = (res >> 1) + bits;
            end else begin
               res = res >> 1;
            end
            bits = bits >> 2;
         end
         return longint'(res);
      endfunction

      function longint branch(longint s1, longint s2, longint u);
         return fsqrt(fmul(s1, sat(ONE - fdiv(fmul(u, u), s2))));
      endfunction

      function longint hsq(longint v);
         longint unsigned m;
         m = (v < 0) ? -v : v;
         return sat(longint'((m * m) >> HSQ_SHIFT));
      endfunction

      function coord_type clamp_coord(longint v);
         if (v > 64'sd8388607) v = 64'sd8388607;
         if (v < -64'sd8388608) v = -64'sd8388608;
         return coord_type'(v);
      endfunction

      function void span_range(longint d, longint v, longint s1, longint s2,
                               output longint lo, output longint hi);
         longint half, r;
         half = (2 * d + v) >>> 1;
         r    = fsqrt(fmul(s2, sat(ONE - fdiv(fmul(2 * d, 2 * d), s1))));
         if (v < 0) begin
            lo = sat(d - r);
            hi = sat(half);
         end else begin
            lo = sat(2 * d - half);
            hi = sat(d + r);
         end
      endfunction

      function point_type predict_corner(logic [1:0] c, longint d, longint dv, longint hs1,
                                         longint hs2, longint vs1, longint vs2,
                                         longint lo, longint hi);
         longint unsigned level, gap[2];
         longint    xs[2], yh[2], yv[2], quarter, r, g;
         int        w;
         bit        top;
         point_type p;
         level = 0;
         top   = (c == CORNER_A || c == CORNER_B);
         forever begin
            quarter = (hi - lo) >>> 2;
            level++;
            xs[0] = lo + quarter;
            xs[1] = hi - quarter;
            for (int k = 0; k < 2; k++) begin
               if (top) begin
                  r     = branch(hs1, hs2, xs[k]);
                  yh[k] = (dv < 0) ? sat(d + r) : sat(d - r);
               end else begin
                  r     = branch(hs1, hs2, sat(xs[k] - 2 * d));
                  yh[k] = (dv < 0) ? sat(d - r) : sat(d + r);
               end
               r     = branch(vs1, vs2, sat(xs[k] - d));
               yv[k] = (c == CORNER_A || c == CORNER_D) ? sat(2 * d - r) : r;
               g      = yv[k] - yh[k];
               gap[k] = (g < 0) ? -g : g;
            end
            w = (gap[0] < gap[1]) ? 0 : 1;
            if (gap[w] < accuracy || level > max_depth) begin
               p.corner = c;
               p.x      = clamp_coord(xs[w]);
               p.y      = clamp_coord((yh[w] + yv[w]) >>> 1);
               p.last   = 1'b0;
               return p;
            end
            if (w == 0) hi = hi - 2 * quarter;
            else lo = lo + 2 * quarter;
         end
      endfunction

      function void note_shot(coord_type ab, coord_type bc, coord_type cd, coord_type ad);
         longint    d, dab, dbc, dcd, dad, dd, lo, hi;
         longint    ab1, ab2, bc1, bc2, cd1, cd2, ad1, ad2;
         logic [1:0] order[4];
         point_type p;
         order = '{CORNER_A, CORNER_D, CORNER_B, CORNER_C};
         d   = longint'(half_spacing);
         dab = ab; dbc = bc; dcd = cd; dad = ad;
         dd  = fmul(d, d);
         ab1 = hsq(dab); ab2 = sat(hsq(dab) - dd);
         bc1 = sat(hsq(dbc) - dd); bc2 = hsq(dbc);
         cd1 = hsq(dcd); cd2 = sat(hsq(dcd) - dd);
         ad1 = sat(hsq(dad) - dd); ad2 = hsq(dad);
         for (int k = 0; k < 4; k++) begin
            if (k < 2) span_range(d, dad, ad1, ad2, lo, hi);
            else span_range(d, dbc, bc1, bc2, lo, hi);
            if (order[k] == CORNER_A || order[k] == CORNER_B)
               p = predict_corner(order[k], d, dab, ab1, ab2,
                                  (k < 2) ? ad1 : bc1, (k < 2) ? ad2 : bc2, lo, hi);
            else
               p = predict_corner(order[k], d, dcd, cd1, cd2,
                                  (k < 2) ? ad1 : bc1, (k < 2) ? ad2 : bc2, lo, hi);
            p.last = (k == 3);
            expected_points.push_back(p);
         end
      endfunction

      function void check_point(logic [1:0] c, coord_type x, coord_type y, logic last);
         point_type e;
         if (expected_points.size() == 0) begin
            $display("%0t unexpected result beat corner %0d x %h y %h", $time, c, x, y);
            errors++;
            return;
         end
         e = expected_points.pop_front();
         if (c !== e.corner) begin
            $display("%0t corner_id expected %0d actual %0d", $time, e.corner, c);
            errors++;
         end
         if (x !== e.x) begin
            $display("%0t x_pos expected %h actual %h", $time, e.x, x);
            errors++;
         end
         if (y !== e.y) begin
            $display("%0t y_pos expected %h actual %h", $time, e.y, y);
            errors++;
         end
         if (last !== e.last) begin
            $display("%0t last expected %b actual %b", $time, e.last, last);
            errors++;
         end
      endfunction
   endclass

   logic       clock, reset, start, busy;
   coord_type  req_diff_ab, req_diff_bc, req_diff_cd, req_diff_ad;
   logic       rsp_valid, rsp_last;
   logic [1:0] rsp_corner_id;
   coord_type  rsp_x_pos, rsp_y_pos;
   logic       csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   hyperbola_board board = new();
   int idle_pct  = 0;
   int quiet_cnt = 0;

   tdoa_hyperbola_intersect_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_diff_ab(req_diff_ab), .req_diff_bc(req_diff_bc),
      .req_diff_cd(req_diff_cd), .req_diff_ad(req_diff_ad),
      .rsp_valid(rsp_valid), .rsp_corner_id(rsp_corner_id),
      .rsp_x_pos(rsp_x_pos), .rsp_y_pos(rsp_y_pos), .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_point(rsp_corner_id, rsp_x_pos, rsp_y_pos, rsp_last);
   end

   // Counts cycles with no beat in either direction.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         quiet_cnt <= 0;
      end else begin
         quiet_cnt <= quiet_cnt + 1;
         if (quiet_cnt >= WATCHDOG) begin
            $display("%0t watchdog expired", $time);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic fire_shot(coord_type ab, coord_type bc, coord_type cd, coord_type ad);
      start       <= 1'b1;
      req_diff_ab <= ab;
      req_diff_bc <= bc;
      req_diff_cd <= cd;
      req_diff_ad <= ad;
      do @(posedge clock); while (busy);
      board.note_shot(ab, bc, cd, ad);
      // A random pause after the beat; with none, start stays high for the next shot.
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic drain;
      start <= 1'b0;
      wait (board.expected_points.size() == 0);
      @(posedge clock);
      repeat (20) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // The write enable drops for one cycle after each write.
   task automatic write_csr(csr_idx_type idx, longint unsigned value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_HALF_SPACING: board.half_spacing = value & 64'h3FFFFF;
         CSR_ACCURACY:     board.accuracy     = value & 64'h1FFFFF;
         default:          board.max_depth    = value & 64'h3F;
      endcase
      @(posedge clock);
   endtask

   function automatic coord_type pick_diff();
      longint span2;
      if ($urandom_range(99) < 30) return coord_type'($urandom);
      span2 = 2 * longint'(board.half_spacing) + 1;
      if (span2 > 64'sd8388607) span2 = 64'sd8388607;
      return coord_type'(longint'($urandom_range(32'(2 * span2))) - span2);
   endfunction

   initial begin
      coord_type mx, mn;
      int        phases[4];
      mx = 24'sh7FFFFF;
      mn = -24'sh800000;
      phases = '{0, 68, 0, 33};
      reset = 1'b1; start = 1'b0; csr_wr_en = 1'b0; csr_index = '0; csr_wdata = '0;
      req_diff_ab = '0; req_diff_bc = '0; req_diff_cd = '0; req_diff_ad = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings, then zero and extreme differences.
      fire_shot(24'sh040000, -24'sh020000, 24'sh030000, -24'sh010000);
      drain();
      write_csr(CSR_MAX_DEPTH, 2);
      fire_shot(0, 0, 0, 0);
      fire_shot(mx, mx, mx, mx);
      fire_shot(mn, mn, mn, mn);
      fire_shot(mx, mn, mx, mn);
      fire_shot(mn, mx, mn, mx);
      fire_shot(-1, 1, -1, 1);
      // Differences beyond the spacing drive the roots negative, so they saturate to zero.
      fire_shot(24'sh300000, -24'sh300000, 24'sh300000, -24'sh300000);
      drain();
      write_csr(CSR_ACCURACY, 1048576);
      fire_shot(24'sh020000, 24'sh010000, -24'sh020000, 24'sh008000);
      drain();
      write_csr(CSR_ACCURACY, 0);
      write_csr(CSR_HALF_SPACING, 1);
      fire_shot(1, -1, 0, 2);
      fire_shot(mx, 0, mn, 0);
      drain();
      write_csr(CSR_HALF_SPACING, 4194303);
      fire_shot(24'sh200000, -24'sh100000, 24'sh180000, -24'sh080000);
      fire_shot(mn, mx, 0, -1);
      drain();
      write_csr(CSR_MAX_DEPTH, 1);
      write_csr(CSR_HALF_SPACING, 524288);
      fire_shot(24'sh050000, 24'sh050000, -24'sh050000, -24'sh050000);
      drain();
      write_csr(CSR_MAX_DEPTH, 40);
      fire_shot(24'sh012345, -24'sh023456, 24'sh034567, -24'sh045678);
      drain();
      write_csr(CSR_MAX_DEPTH, 63);
      write_csr(CSR_ACCURACY, 1048576);
      fire_shot(24'sh010000, 24'sh010000, 24'sh010000, 24'sh010000);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = phases[ph];
         write_csr(CSR_HALF_SPACING, ($urandom_range(3) == 0) ? $urandom_range(1, 4194303)
                                                              : $urandom_range(65536, 1048576));
         write_csr(CSR_ACCURACY, ($urandom_range(3) == 0) ? $urandom_range(0, 1048576)
                                                          : $urandom_range(0, 4096));
         write_csr(CSR_MAX_DEPTH, $urandom_range(1, 4));
         for (int i = 0; i < 25; i++) begin
            fire_shot(pick_diff(), pick_diff(), pick_diff(), pick_diff());
            if (i == 12) begin
               // Hold the next shot until every point of this one has come out.
               start <= 1'b0;
               wait (board.expected_points.size() == 0);
               @(posedge clock);
            end
         end
         drain();
      end

      repeat (200) @(posedge clock);
      if (board.errors == 0 && board.expected_points.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
